FILE: sv/wsfd_pkg.sv
// Shared types and constants for the WebSocket frame decoder.
// No dependencies; imported by every module of the block.
package wsfd_pkg;

    localparam int OUT_LEN_W   = 63;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam logic [2:0] KIND_PAYLOAD   = 3'd0;
    localparam logic [2:0] KIND_EMPTY     = 3'd1;
    localparam logic [2:0] KIND_BAD_OP    = 3'd2;
    localparam logic [2:0] KIND_MASKED    = 3'd3;
    localparam logic [2:0] KIND_TOO_LARGE = 3'd4;

    localparam logic [3:0] OP_CONT   = 4'h0;
    localparam logic [3:0] OP_TEXT   = 4'h1;
    localparam logic [3:0] OP_BINARY = 4'h2;
    localparam logic [3:0] OP_CLOSE  = 4'h8;
    localparam logic [3:0] OP_PING   = 4'h9;
    localparam logic [3:0] OP_PONG   = 4'hA;

    localparam logic [2:0] FT_CONT   = 3'd0;
    localparam logic [2:0] FT_TEXT   = 3'd1;
    localparam logic [2:0] FT_BINARY = 3'd2;
    localparam logic [2:0] FT_CLOSE  = 3'd3;
    localparam logic [2:0] FT_PING   = 3'd4;
    localparam logic [2:0] FT_PONG   = 3'd5;

    localparam logic [7:0] LEN_CODE_16 = 8'd126;
    localparam logic [7:0] LEN_CODE_64 = 8'd127;

    localparam logic [3:0] HEAD_SIZE_2  = 4'd2;
    localparam logic [3:0] HEAD_SIZE_4  = 4'd4;
    localparam logic [3:0] HEAD_SIZE_10 = 4'd10;

    typedef struct packed {
        logic [2:0]           kind;
        logic [7:0]           data_byte;
        logic [2:0]           frame_type;
        logic                 continued;
        logic [OUT_LEN_W-1:0] byte_offset;
        logic [OUT_LEN_W-1:0] frame_length;
        logic                 last_of_frame;
    } res_t;

endpackage

FILE: sv/wsfd_front.sv
// Front end: frame head parser and payload byte classifier.
// Depends on wsfd_pkg; emits one optional request per accepted byte.
module wsfd_front #(
    parameter int LENGTH_BITS = 64
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           accept,
    input  logic [7:0]     in_byte,
    output logic           push,
    output wsfd_pkg::res_t res
);
    import wsfd_pkg::*;

    localparam int LW = LENGTH_BITS - 1;

    logic          in_payload_reg, in_payload_next;
    logic [3:0]    head_count_reg, head_count_next;
    logic [3:0]    head_size_reg, head_size_next;
    logic [2:0]    type_reg, type_next;
    logic          cont_reg, cont_next;
    logic [LW-1:0] len_reg, len_next;
    logic          ovf_reg, ovf_next;
    logic [LW-1:0] off_reg, off_next;

    logic [LW+7:0] shifted;
    logic [LW-1:0] off_inc;
    logic [3:0]    count_inc;
    logic [2:0]    type_dec;
    logic          op_known;
    logic          do_err;
    logic [2:0]    err_kind;
    logic          do_done;
    logic [LW-1:0] dn_len;
    logic          dn_ovf;
    logic          do_clear;

    always_comb
    begin
        op_known = 1'b1;
        type_dec = FT_CONT;
        case (in_byte[3:0])
            OP_CONT:   type_dec = FT_CONT;
            OP_TEXT:   type_dec = FT_TEXT;
            OP_BINARY: type_dec = FT_BINARY;
            OP_CLOSE:  type_dec = FT_CLOSE;
            OP_PING:   type_dec = FT_PING;
            OP_PONG:   type_dec = FT_PONG;
            default:   op_known = 1'b0;
        endcase
    end

    always_comb
    begin
        in_payload_next = in_payload_reg;
        head_count_next = head_count_reg;
        head_size_next  = head_size_reg;
        type_next       = type_reg;
        cont_next       = cont_reg;
        len_next        = len_reg;
        ovf_next        = ovf_reg;
        off_next        = off_reg;
        push            = 1'b0;
        res             = '0;
        do_err          = 1'b0;
        err_kind        = KIND_BAD_OP;
        do_done         = 1'b0;
        dn_len          = len_reg;
        dn_ovf          = ovf_reg;
        do_clear        = 1'b0;

        shifted   = {len_reg, in_byte};
        off_inc   = off_reg + LW'(1);
        count_inc = head_count_reg + 4'd1;

        if (accept)
        begin
            if (in_payload_reg)
            begin
                push               = 1'b1;
                res.kind           = KIND_PAYLOAD;
                res.data_byte      = in_byte;
                res.frame_type     = type_reg;
                res.continued      = cont_reg;
                res.byte_offset    = OUT_LEN_W'(off_reg);
                res.frame_length   = OUT_LEN_W'(len_reg);
                res.last_of_frame  = (off_inc == len_reg);
                if (off_inc == len_reg)
                    do_clear = 1'b1;
                else
                    off_next = off_inc;
            end
            else if (head_count_reg == 4'd0)
            begin
                if (!op_known)
                begin
                    do_err   = 1'b1;
                    err_kind = KIND_BAD_OP;
                end
                else
                begin
                    type_next       = type_dec;
                    cont_next       = (in_byte[3:0] == OP_CONT) && !in_byte[7];
                    len_next        = '0;
                    ovf_next        = 1'b0;
                    off_next        = '0;
                    head_count_next = 4'd1;
                end
            end
            else if (head_count_reg == 4'd1)
            begin
                if (in_byte[7])
                begin
                    do_err   = 1'b1;
                    err_kind = KIND_MASKED;
                end
                else
                begin
                    head_count_next = 4'd2;
                    len_next        = '0;
                    ovf_next        = 1'b0;
                    if (in_byte == LEN_CODE_16)
                        head_size_next = HEAD_SIZE_4;
                    else if (in_byte == LEN_CODE_64)
                        head_size_next = HEAD_SIZE_10;
                    else
                    begin
                        head_size_next = HEAD_SIZE_2;
                        len_next       = LW'(in_byte);
                        do_done        = 1'b1;
                        dn_len         = LW'(in_byte);
                        dn_ovf         = 1'b0;
                    end
                end
            end
            else
            begin
                len_next        = shifted[LW-1:0];
                ovf_next        = ovf_reg | (|shifted[LW+7:LW]);
                head_count_next = count_inc;
                if (count_inc >= head_size_reg)
                begin
                    do_done = 1'b1;
                    dn_len  = shifted[LW-1:0];
                    dn_ovf  = ovf_reg | (|shifted[LW+7:LW]);
                end
            end

            if (do_done)
            begin
                if (dn_ovf)
                begin
                    do_err   = 1'b1;
                    err_kind = KIND_TOO_LARGE;
                end
                else if (dn_len == '0)
                begin
                    push              = 1'b1;
                    res.kind          = KIND_EMPTY;
                    res.frame_type    = type_reg;
                    res.continued     = cont_reg;
                    res.last_of_frame = 1'b1;
                    do_clear          = 1'b1;
                end
                else
                begin
                    in_payload_next = 1'b1;
                    off_next        = '0;
                end
            end

            if (do_err)
            begin
                push     = 1'b1;
                res      = '0;
                res.kind = err_kind;
                do_clear = 1'b1;
            end

            if (do_clear)
            begin
                in_payload_next = 1'b0;
                head_count_next = 4'd0;
                head_size_next  = 4'd0;
                type_next       = FT_CONT;
                cont_next       = 1'b0;
                len_next        = '0;
                ovf_next        = 1'b0;
                off_next        = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_payload_reg <= 1'b0;
            head_count_reg <= 4'd0;
            head_size_reg  <= 4'd0;
            type_reg       <= FT_CONT;
            cont_reg       <= 1'b0;
            len_reg        <= '0;
            ovf_reg        <= 1'b0;
            off_reg        <= '0;
        end
        else
        begin
            in_payload_reg <= in_payload_next;
            head_count_reg <= head_count_next;
            head_size_reg  <= head_size_next;
            type_reg       <= type_next;
            cont_reg       <= cont_next;
            len_reg        <= len_next;
            ovf_reg        <= ovf_next;
            off_reg        <= off_next;
        end
    end

endmodule

FILE: sv/wsfd_queue.sv
// Short request queue between the front end and the output stage.
// Depends on wsfd_pkg for the request type and depth.
module wsfd_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  wsfd_pkg::res_t din,
    input  logic           pop,
    output wsfd_pkg::res_t dout,
    output logic           full,
    output logic           empty
);
    import wsfd_pkg::*;

    res_t              mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]   count_reg, count_next;
    logic              do_push;
    logic              do_pop;

    assign full    = (count_reg == (QPTR_W + 1)'(QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign dout    = mem_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + (QPTR_W + 1)'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - (QPTR_W + 1)'(1);
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= din;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

FILE: sv/wsfd_back.sv
// Back end: output register stage that drains the request queue.
// Depends on wsfd_pkg for the request type.
module wsfd_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           q_empty,
    input  wsfd_pkg::res_t q_data,
    output logic           pop,
    output logic           res_valid,
    input  logic           res_stall,
    output wsfd_pkg::res_t res
);
    import wsfd_pkg::*;

    logic valid_reg, valid_next;
    res_t res_reg;

    assign pop       = !q_empty && (!valid_reg || !res_stall);
    assign valid_next = pop ? 1'b1 : (valid_reg && res_stall);
    assign res_valid = valid_reg;
    assign res       = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (pop)
            res_reg <= q_data;
    end

endmodule

FILE: sv/websocket_frame_decoder_top.sv
// WebSocket frame decoder: takes one stream byte per cycle while byte_stall is
// low, parses the 2, 4 or 10 byte frame head and emits one request per payload
// byte, one per empty frame and one per error (unknown opcode, masked frame,
// length too large). The front end handles each byte as it is accepted, so
// bytes are taken back to back; head bytes produce a request only for an empty
// frame or an error. Requests pass through a four-entry queue and a registered
// output stage, where res_stall holds a result until it is taken. byte_stall
// rises only when the queue is full. LENGTH_BITS sets the supported frame
// length: lengths that need LENGTH_BITS bits or more are reported as too large.
// Depends on wsfd_pkg, wsfd_front, wsfd_queue and wsfd_back.
module websocket_frame_decoder_top #(
    parameter int LENGTH_BITS = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        byte_valid,
    output logic        byte_stall,
    input  logic [7:0]  in_byte,
    output logic        res_valid,
    input  logic        res_stall,
    output logic [2:0]  kind,
    output logic [7:0]  data_byte,
    output logic [2:0]  frame_type,
    output logic        continued,
    output logic [62:0] byte_offset,
    output logic [62:0] frame_length,
    output logic        last_of_frame
);
    import wsfd_pkg::*;

    logic accept;
    logic push;
    res_t front_res;
    res_t q_data;
    logic q_full;
    logic q_empty;
    logic pop;
    res_t out_res;

    assign byte_stall = q_full;
    assign accept     = byte_valid && !q_full;

    wsfd_front #(
        .LENGTH_BITS(LENGTH_BITS)
    ) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .in_byte (in_byte),
        .push    (push),
        .res     (front_res)
    );

    wsfd_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .din   (front_res),
        .pop   (pop),
        .dout  (q_data),
        .full  (q_full),
        .empty (q_empty)
    );

    wsfd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_data    (q_data),
        .pop       (pop),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (out_res)
    );

    assign kind          = out_res.kind;
    assign data_byte     = out_res.data_byte;
    assign frame_type    = out_res.frame_type;
    assign continued     = out_res.continued;
    assign byte_offset   = out_res.byte_offset;
    assign frame_length  = out_res.frame_length;
    assign last_of_frame = out_res.last_of_frame;

    a_empty_frame: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && kind == KIND_EMPTY |-> last_of_frame && frame_length == '0)
        else $error("empty frame request malformed");

    a_offset_range: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && kind == KIND_PAYLOAD |-> byte_offset < frame_length)
        else $error("payload offset beyond frame length");

    a_last_byte: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && kind == KIND_PAYLOAD && last_of_frame
        |-> byte_offset + 63'd1 == frame_length)
        else $error("last mark on a non-final payload byte");

    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        q_full |-> !push)
        else $error("request pushed into full queue");

endmodule
